@@ hw/rtl/qrs_pkg.sv @@
package qrs_pkg;

  localparam int unsigned COEF_W     = 16;
  localparam int unsigned DISC_PAIRS = 18;
  localparam int unsigned MAG_W      = 2 * DISC_PAIRS;
  localparam int unsigned DEN_W      = COEF_W + 1;
  localparam int unsigned LANES      = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned REAL_W     = 32;
  localparam int unsigned IMAG_W     = 31;

  typedef enum logic [KIND_W-1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_A_ZERO   = 2'd3
  } root_kind_e;

endpackage

@@ hw/rtl/qrs_sqrt_cell.sv @@
module qrs_sqrt_cell #(
  parameter int unsigned ROOT_W = 34,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [ROOT_W+1:0]               rem_i,
  input  logic [ROOT_W-1:0]               root_i,
  input  logic [qrs_pkg::MAG_W-1:0]       mag_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [ROOT_W+1:0]               rem_o,
  output logic [ROOT_W-1:0]               root_o,
  output logic [qrs_pkg::MAG_W-1:0]       mag_o,
  output logic [SIDE_W-1:0]               side_o
);
  import qrs_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;

  logic             valid_q;
  logic [REM_W-1:0] rem_q, rem_d, shifted, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [MAG_W-1:0] mag_q;
  logic [SIDE_W-1:0] side_q;

  // one restoring step: bring down the top pair, try 4*root+1
  always_comb begin
    shifted = {rem_i[REM_W-3:0], mag_i[MAG_W-1 -: 2]};
    trial   = {root_i, 2'b01};
    if (shifted >= trial) begin
      rem_d  = shifted - trial;
      root_d = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = shifted;
      root_d = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    mag_q  <= {mag_i[MAG_W-3:0], 2'b00};
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign mag_o   = mag_q;
  assign side_o  = side_q;

endmodule

@@ hw/rtl/qrs_div_cell.sv @@
module qrs_div_cell #(
  parameter int unsigned MW     = 35,
  parameter int unsigned SIDE_W = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [qrs_pkg::DEN_W-1:0]   den_i,
  input  logic [MW-1:0]               num_i [qrs_pkg::LANES],
  input  logic [qrs_pkg::DEN_W-1:0]   rem_i [qrs_pkg::LANES],
  input  logic [MW-1:0]               quo_i [qrs_pkg::LANES],
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [qrs_pkg::DEN_W-1:0]   den_o,
  output logic [MW-1:0]               num_o [qrs_pkg::LANES],
  output logic [qrs_pkg::DEN_W-1:0]   rem_o [qrs_pkg::LANES],
  output logic [MW-1:0]               quo_o [qrs_pkg::LANES],
  output logic [SIDE_W-1:0]           side_o
);
  import qrs_pkg::*;

  logic             valid_q;
  logic [DEN_W-1:0] den_q;
  logic [MW-1:0]    num_q [LANES];
  logic [DEN_W-1:0] rem_q [LANES];
  logic [MW-1:0]    quo_q [LANES];
  logic [SIDE_W-1:0] side_q;
  logic [DEN_W:0]   part  [LANES];
  logic [DEN_W-1:0] rem_d [LANES];
  logic [LANES-1:0] qbit;

  // one quotient bit per lane, all lanes share the divisor
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      part[l] = {rem_i[l], num_i[l][MW-1]};
      qbit[l] = (part[l] >= {1'b0, den_i});
      rem_d[l] = qbit[l] ? DEN_W'(part[l] - {1'b0, den_i}) : part[l][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_i;
    side_q <= side_i;
    for (int l = 0; l < LANES; l++) begin
      num_q[l] <= {num_i[l][MW-2:0], 1'b0};
      rem_q[l] <= rem_d[l];
      quo_q[l] <= {quo_i[l][MW-2:0], qbit[l]};
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

@@ hw/rtl/quadratic_root_solver_top.sv @@
// Channel  | Direction | Ports                                          | Beat taken when
// ---------+-----------+------------------------------------------------+-----------------
// command  | in        | start_i, coef_a_i, coef_b_i, coef_c_i, busy_o  | start_i && !busy_o
// result   | out       | done_o, root_kind_o, root_one_real_o,          | done_o (one cycle)
//          |           | root_two_real_o, imag_part_o                   |
//
// One coefficient beat may enter every cycle; busy_o stays low.
// The pipeline holds two multiply/discriminant stages, one square root cell per root bit, one operand
// prep stage, one divider cell per quotient bit, and the saturating output register.
// Reset clears only the valid bits of the stages and cell chains; no clearing pass is needed.
// The receiver cannot stall, so nothing is ever held back inside the pipeline.
module quadratic_root_solver_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a_i,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b_i,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c_i,
  output logic                              done_o,
  output logic [qrs_pkg::KIND_W-1:0]        root_kind_o,
  output logic signed [qrs_pkg::REAL_W-1:0] root_one_real_o,
  output logic signed [qrs_pkg::REAL_W-1:0] root_two_real_o,
  output logic [qrs_pkg::IMAG_W-1:0]        imag_part_o
);
  import qrs_pkg::*;

  localparam int unsigned N       = DISC_PAIRS + FRAC_BITS;  // root bits
  localparam int unsigned REM_W   = N + 2;
  localparam int unsigned NB_W    = COEF_W + 1 + FRAC_BITS;  // -b scaled
  localparam int unsigned NW      = N + 2;                   // signed numerator
  localparam int unsigned MW      = N + 1;                   // numerator magnitude
  localparam int unsigned D_W     = 2 * COEF_W + 3;          // discriminant
  localparam int unsigned SQ_SIDE = 3 + NB_W + COEF_W;
  localparam int unsigned DV_SIDE = KIND_W + 2;

  logic [REAL_W:0] sat_pos_lim, sat_neg_lim;
  assign sat_pos_lim = {2'b00, {(REAL_W-1){1'b1}}};
  assign sat_neg_lim = {2'b01, {(REAL_W-1){1'b0}}};

  // ---------------- stage 1: products ----------------
  logic                     v1_q;
  logic signed [2*COEF_W-1:0] bb_q, ac_q;
  logic signed [COEF_W-1:0] a1_q, b1_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    bb_q <= coef_b_i * coef_b_i;
    ac_q <= coef_a_i * coef_c_i;
    a1_q <= coef_a_i;
    b1_q <= coef_b_i;
  end

  // ---------------- stage 2: discriminant and its magnitude ----------------
  logic signed [D_W-1:0]  disc;
  logic [D_W-1:0]         disc_abs;
  logic signed [NB_W-1:0] b_ext, nb;

  always_comb begin
    disc     = D_W'(bb_q) - (D_W'(ac_q) <<< 2);
    disc_abs = disc[D_W-1] ? D_W'(-disc) : disc;
    b_ext    = NB_W'(b1_q);
    nb       = (-b_ext) <<< FRAC_BITS;
  end

  logic                 v2_q;
  logic [MAG_W-1:0]     mag2_q;
  logic [SQ_SIDE-1:0]   side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  // side: a is zero, d > 0, d < 0, scaled -b, a
  always_ff @(posedge clk_i) begin
    mag2_q  <= MAG_W'(disc_abs);
    side2_q <= {(a1_q == '0), (!disc[D_W-1] && (disc != '0)), disc[D_W-1], nb, a1_q};
  end

  // ---------------- square root chain ----------------
  logic               sq_v    [N+1];
  logic [REM_W-1:0]   sq_rem  [N+1];
  logic [N-1:0]       sq_root [N+1];
  logic [MAG_W-1:0]   sq_mag  [N+1];
  logic [SQ_SIDE-1:0] sq_side [N+1];

  assign sq_v[0]    = v2_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_mag[0]  = mag2_q;
  assign sq_side[0] = side2_q;

  for (genvar g = 0; g < N; g++) begin : g_sqrt
    qrs_sqrt_cell #(
      .ROOT_W (N),
      .SIDE_W (SQ_SIDE)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .mag_i   (sq_mag[g]),
      .side_i  (sq_side[g]),
      .valid_o (sq_v[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .mag_o   (sq_mag[g+1]),
      .side_o  (sq_side[g+1])
    );
  end

  // ---------------- prep: numerators, divisor, signs ----------------
  logic                     p_a_zero, p_d_pos, p_d_neg;
  logic signed [NB_W-1:0]   p_nb;
  logic signed [COEF_W-1:0] p_a;
  logic signed [NW-1:0]     s_ext, nb_w, num1, num2;
  logic [MW-1:0]            mag_n1, mag_n2, mag_n3;
  logic [DEN_W-1:0]         den;
  logic [KIND_W-1:0]        kind;
  logic                     sgn1, sgn2;

  always_comb begin
    {p_a_zero, p_d_pos, p_d_neg, p_nb, p_a} = sq_side[N];
    s_ext = NW'(sq_root[N]);
    nb_w  = NW'(p_nb);
    num1  = p_d_pos ? nb_w + s_ext : nb_w;
    num2  = p_d_pos ? nb_w - s_ext : nb_w;
    mag_n1 = num1[NW-1] ? MW'(-num1) : MW'(num1);
    mag_n2 = num2[NW-1] ? MW'(-num2) : MW'(num2);
    mag_n3 = p_d_neg ? MW'(sq_root[N]) : '0;
    sgn1  = num1[NW-1] ^ p_a[COEF_W-1];
    sgn2  = num2[NW-1] ^ p_a[COEF_W-1];
    // hold a harmless divisor when a is zero; outputs are forced later
    if (p_a_zero) begin
      den = DEN_W'(1);
    end else if (p_a[COEF_W-1]) begin
      den = DEN_W'(-p_a) << 1;
    end else begin
      den = DEN_W'(p_a) << 1;
    end
    priority if (p_a_zero) begin
      kind = KIND_A_ZERO;
    end else if (p_d_pos) begin
      kind = KIND_TWO_REAL;
    end else if (p_d_neg) begin
      kind = KIND_COMPLEX;
    end else begin
      kind = KIND_DOUBLE;
    end
  end

  logic               dv_v    [MW+1];
  logic [DEN_W-1:0]   dv_den  [MW+1];
  logic [MW-1:0]      dv_num  [MW+1][LANES];
  logic [DEN_W-1:0]   dv_rem  [MW+1][LANES];
  logic [MW-1:0]      dv_quo  [MW+1][LANES];
  logic [DV_SIDE-1:0] dv_side [MW+1];

  logic               p_v_q;
  logic [DEN_W-1:0]   p_den_q;
  logic [MW-1:0]      p_num_q [LANES];
  logic [DV_SIDE-1:0] p_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= sq_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    p_den_q    <= den;
    p_num_q[0] <= mag_n1;
    p_num_q[1] <= mag_n2;
    p_num_q[2] <= mag_n3;
    p_side_q   <= {kind, sgn1, sgn2};
  end

  // ---------------- divider chain ----------------
  assign dv_v[0]    = p_v_q;
  assign dv_den[0]  = p_den_q;
  assign dv_num[0]  = p_num_q;
  assign dv_side[0] = p_side_q;
  for (genvar l = 0; l < LANES; l++) begin : g_dv_init
    assign dv_rem[0][l] = '0;
    assign dv_quo[0][l] = '0;
  end

  for (genvar g = 0; g < MW; g++) begin : g_div
    qrs_div_cell #(
      .MW     (MW),
      .SIDE_W (DV_SIDE)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[g]),
      .den_i   (dv_den[g]),
      .num_i   (dv_num[g]),
      .rem_i   (dv_rem[g]),
      .quo_i   (dv_quo[g]),
      .side_i  (dv_side[g]),
      .valid_o (dv_v[g+1]),
      .den_o   (dv_den[g+1]),
      .num_o   (dv_num[g+1]),
      .rem_o   (dv_rem[g+1]),
      .quo_o   (dv_quo[g+1]),
      .side_o  (dv_side[g+1])
    );
  end

  // ---------------- saturate and drive the result ----------------
  function automatic logic [REAL_W-1:0] sat_real(input logic [REAL_W+MW:0] q,
                                                 input logic sgn,
                                                 input logic [REAL_W:0] pos_lim,
                                                 input logic [REAL_W:0] neg_lim);
    logic [REAL_W+MW:0] neg_q;
    neg_q = -q;
    if (sgn) begin
      sat_real = (q > (REAL_W+MW+1)'(neg_lim)) ? neg_lim[REAL_W-1:0] : neg_q[REAL_W-1:0];
    end else begin
      sat_real = (q > (REAL_W+MW+1)'(pos_lim)) ? pos_lim[REAL_W-1:0] : q[REAL_W-1:0];
    end
  endfunction

  logic [KIND_W-1:0] f_kind;
  logic              f_s1, f_s2;
  logic [REAL_W-1:0] r1_d, r2_d;
  logic [IMAG_W-1:0] im_d;
  logic [REAL_W+MW:0] q1, q2, q3;

  always_comb begin
    {f_kind, f_s1, f_s2} = dv_side[MW];
    q1 = (REAL_W+MW+1)'(dv_quo[MW][0]);
    q2 = (REAL_W+MW+1)'(dv_quo[MW][1]);
    q3 = (REAL_W+MW+1)'(dv_quo[MW][2]);
    r1_d = sat_real(q1, f_s1, sat_pos_lim, sat_neg_lim);
    r2_d = sat_real(q2, f_s2, sat_pos_lim, sat_neg_lim);
    im_d = (q3 > (REAL_W+MW+1)'(sat_pos_lim)) ? {IMAG_W{1'b1}} : q3[IMAG_W-1:0];
    // drop every number when a is zero
    if (f_kind == KIND_A_ZERO) begin
      r1_d = '0;
      r2_d = '0;
      im_d = '0;
    end
  end

  logic              done_q;
  logic [KIND_W-1:0] kind_q;
  logic [REAL_W-1:0] r1_q, r2_q;
  logic [IMAG_W-1:0] im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= f_kind;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    im_q   <= im_d;
  end

  assign done_o          = done_q;
  assign root_kind_o     = kind_q;
  assign root_one_real_o = r1_q;
  assign root_two_real_o = r2_q;
  assign imag_part_o     = im_q;

endmodule
